[rtl/bsfc_pkg.sv]
// types, sizes and codes shared by the byte stream fifo and its checker
`timescale 1ns / 1ps

package bsfc_pkg;

	localparam int DEPTH  = 1024;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int FILL_W = 11;

	typedef enum logic [2:0] {
		FN_WRITE    = 3'd0,
		FN_READ     = 3'd1,
		FN_COMPLETE = 3'd2,
		FN_CANCEL   = 3'd3,
		FN_ERROR    = 3'd4,
		FN_ARM_RD   = 3'd5,
		FN_ARM_SP   = 3'd6,
		FN_NOP      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_ACTIVE    = 2'd0,
		ST_COMPLETED = 2'd1,
		ST_CANCELED  = 2'd2,
		ST_ERROR     = 2'd3
	} life_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  data_in;
		logic [63:0] total_bytes;
	} req_t;

	typedef struct packed {
		logic [7:0]        data_out;
		logic              data_valid;
		logic              write_accepted;
		logic [1:0]        stream_state;
		logic              drained;
		logic [FILL_W-1:0] fill_level;
		logic [63:0]       consumed_total;
		logic [63:0]       final_total;
		logic              read_wake;
		logic              space_wake;
	} rsp_t;

endpackage

[rtl/byte_stream_fifo_with_close.sv]
// circular byte fifo with stream lifecycle and one-shot wakes
//
//  channel | valid     | stall     | payload | direction
//  request | req_valid | req_stall | req     | into block
//  result  | rsp_valid | rsp_stall | rsp     | out of block
//
// one request per cycle while req_stall is low; its result passes through the
// synchronous byte store read and then the output register
// req_stall rises only while a result is held and rsp_stall is high
// arst_n clears pointers, count, totals, lifecycle state and wakes; the byte
// store itself is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module byte_stream_fifo_with_close import bsfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	logic [AW-1:0] head_q, tail_q, head_n, tail_n;
	logic [CW-1:0] cnt_q, cnt_n;
	life_t         life_q, life_n;
	logic [63:0]   tot_q, tot_n, ann_q, ann_n;
	logic          rwa_q, rwa_n, swa_q, swa_n;

	logic we, re, acc, rdv, rw, sw, full, active, req_fire, out_load;

	logic       s1_valid_q;
	rsp_t       s1_q;
	rsp_t       s1_out;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	assign out_load  = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !out_load;
	assign req_fire  = req_valid && !req_stall;
	assign full      = (cnt_q == CW'(DEPTH));
	assign active    = (life_q == ST_ACTIVE);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		cnt_n  = cnt_q;
		life_n = life_q;
		tot_n  = tot_q;
		ann_n  = ann_q;
		rwa_n  = rwa_q;
		swa_n  = swa_q;
		we     = 1'b0;
		re     = 1'b0;
		acc    = 1'b0;
		rdv    = 1'b0;
		rw     = 1'b0;
		sw     = 1'b0;
		case (func_t'(req.func))
			FN_WRITE: begin
				if (active && !full) begin
					we     = 1'b1;
					tail_n = nxt(tail_q);
					cnt_n  = cnt_q + CW'(1);
					acc    = 1'b1;
					rw     = rwa_q;
					rwa_n  = 1'b0;
				end
			end
			FN_READ: begin
				if (cnt_q != '0) begin
					re     = 1'b1;
					head_n = nxt(head_q);
					cnt_n  = cnt_q - CW'(1);
					tot_n  = tot_q + 64'd1;
					rdv    = 1'b1;
					sw     = swa_q;
					swa_n  = 1'b0;
				end
			end
			FN_COMPLETE, FN_CANCEL, FN_ERROR: begin
				if (active) begin
					case (func_t'(req.func))
						FN_COMPLETE: life_n = ST_COMPLETED;
						FN_CANCEL:   life_n = ST_CANCELED;
						default:     life_n = ST_ERROR;
					endcase
					if (func_t'(req.func) == FN_COMPLETE) ann_n = req.total_bytes;
					rw    = rwa_q;
					sw    = swa_q;
					rwa_n = 1'b0;
					swa_n = 1'b0;
				end
			end
			FN_ARM_RD: begin
				if (cnt_q != '0 || !active) rw = 1'b1;
				else rwa_n = 1'b1;
			end
			FN_ARM_SP: begin
				if (!full || !active) sw = 1'b1;
				else swa_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// byte store: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (req_fire && we) mem[tail_q] <= req.data_in;
		if (req_fire && re) rdata_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			life_q      <= ST_ACTIVE;
			tot_q       <= '0;
			ann_q       <= '0;
			rwa_q       <= 1'b0;
			swa_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				head_q <= head_n;
				tail_q <= tail_n;
				cnt_q  <= cnt_n;
				life_q <= life_n;
				tot_q  <= tot_n;
				ann_q  <= ann_n;
				rwa_q  <= rwa_n;
				swa_q  <= swa_n;
			end
			if (req_fire) s1_valid_q <= 1'b1;
			else if (out_load) s1_valid_q <= 1'b0;
			if (out_load) rsp_valid_q <= s1_valid_q;
		end
	end

	// merge the byte store read data into the waiting status
	always_comb begin
		s1_out          = s1_q;
		s1_out.data_out = s1_q.data_valid ? rdata_q : 8'd0;
	end

	// status of the request, waiting for the byte store read data
	always_ff @(posedge clk) begin
		if (req_fire) begin
			s1_q.data_out       <= '0;
			s1_q.data_valid     <= rdv;
			s1_q.write_accepted <= acc;
			s1_q.stream_state   <= life_n;
			s1_q.drained        <= (cnt_n == '0) && (life_n != ST_ACTIVE);
			s1_q.fill_level     <= FILL_W'(cnt_n);
			s1_q.consumed_total <= tot_n;
			s1_q.final_total    <= ann_n;
			s1_q.read_wake      <= rw;
			s1_q.space_wake     <= sw;
		end
		if (out_load && s1_valid_q) rsp_q <= s1_out;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/bsfc_checker.sv]
// port-level checks for the byte stream fifo, bound to the top level
`timescale 1ns / 1ps

module bsfc_checker import bsfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a held result does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// back pressure only passes through from a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

	// a stored byte means the stream was active and holds data
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.write_accepted |->
			rsp.stream_state == ST_ACTIVE && rsp.fill_level != '0 && !rsp.data_valid)
		else $error("write accepted with inconsistent status");

	// drained only with an empty store and an ended stream
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.drained |->
			rsp.fill_level == '0 && rsp.stream_state != ST_ACTIVE)
		else $error("drained reported with data or active stream");

endmodule

bind byte_stream_fifo_with_close bsfc_checker u_bsfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
